// ===== src/ir_distance_table_interpolator_defines.svh =====
// Assertion macros for the IR distance table interpolator.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef IR_DISTANCE_TABLE_INTERPOLATOR_DEFINES_SVH
`define IR_DISTANCE_TABLE_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent holds in the same cycle as the antecedent.
`define IRDTI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IRDTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IRDTI_ASSERT_SAME(lbl, ante, cons, msg)
`define IRDTI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/irdti_pkg.sv =====
package irdti_pkg;

	// Field widths
	localparam int CH_W   = 3;
	localparam int READ_W = 14;
	localparam int DIST_W = 12;

	// Calibration table size and derived widths
	localparam int TABLE_ENTRIES = 14;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	// Interpolation numerator: distance times breakpoint step
	localparam int NUM_W         = READ_W + DIST_W;
	// Divider iteration counter
	localparam int CNT_W         = $clog2(DIST_W + 1);

	// Result kind
	typedef enum logic [1:0] {
		CLAMP_NONE  = 2'd0,
		CLAMP_FIRST = 2'd1,
		CLAMP_LAST  = 2'd2
	} clamp_t;

	// Front sensor breakpoints, ADC counts times 16
	localparam logic [READ_W-1:0] FRONT_AT [TABLE_ENTRIES] = '{
		14'd1904, 14'd1920, 14'd1936, 14'd1952, 14'd1968, 14'd2101, 14'd2320,
		14'd2571, 14'd2880, 14'd3443, 14'd4157, 14'd5210, 14'd6826, 14'd8699
	};

	// Side sensor breakpoints: volts * 1024 / 5 * 16, rounded
	localparam logic [READ_W-1:0] SIDE_AT [TABLE_ENTRIES] = '{
		14'd1311, 14'd1475, 14'd1638, 14'd1802, 14'd1966, 14'd2130, 14'd2294,
		14'd2621, 14'd2949, 14'd3441, 14'd4096, 14'd5079, 14'd6554, 14'd8192
	};

	// Distances in cm times 16, shared by both tables
	localparam logic [DIST_W-1:0] DIST_Q4 [TABLE_ENTRIES] = '{
		12'd2400, 12'd2240, 12'd2080, 12'd1920, 12'd1760, 12'd1600, 12'd1440,
		12'd1280, 12'd1120, 12'd960,  12'd800,  12'd640,  12'd480,  12'd320
	};

	// Breakpoint lookup; unused index codes read as zero
	function automatic logic [READ_W-1:0] bp_at(input logic front,
		input logic [IDX_W-1:0] idx);
		logic [READ_W-1:0] v;
		v = '0;
		if (32'(idx) < TABLE_ENTRIES) begin
			v = front ? FRONT_AT[idx] : SIDE_AT[idx];
		end
		return v;
	endfunction

	// Distance lookup; unused index codes read as zero
	function automatic logic [DIST_W-1:0] dist_at(input logic [IDX_W-1:0] idx);
		logic [DIST_W-1:0] v;
		v = '0;
		if (32'(idx) < TABLE_ENTRIES) begin
			v = DIST_Q4[idx];
		end
		return v;
	endfunction

endpackage

// ===== src/ir_distance_table_interpolator.sv =====
// IR distance table interpolator: one item in (channel on s_tuser, reading on
// s_tdata) gives one item out (distance on m_tdata, clamp kind on m_tuser).
// Channel 0 uses the front table, any other channel the side table. The block
// handles one item at a time and is not ready while it works. A reading at or
// below the first breakpoint is clamped after the low range check, one at or
// above the last entry after the high check. An interpolated reading goes
// on to a linear breakpoint search that finds the segment index k (0 to 12),
// then to the numerator build and the divide. One shared 16-bit subtractor
// does the range checks, the segment search, the offset into the segment and
// the 12 steps of the restoring divide; a 12x14 multiply step and a
// multiply-add step build the numerator. A finished item sits in the output
// register, so the next item may be accepted before it is taken.
`include "ir_distance_table_interpolator_defines.svh"

module ir_distance_table_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [13:0] reading_q4, [15:14] zero
	input  logic [irdti_pkg::CH_W-1:0] s_tuser,  // [2:0] channel
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] distance_q4, [15:12] zero
	output logic [1:0]  m_tuser    // [1:0] clamp_state
);
	import irdti_pkg::*;

	localparam int SUB_W = READ_W + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LO,
		ST_HI,
		ST_SEARCH,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic                front_q;
	logic [READ_W-1:0]   read_q;
	logic [IDX_W-1:0]    seg_q;
	logic [READ_W-1:0]   diff_q;
	logic [READ_W-1:0]   step_q;
	logic [NUM_W-1:0]    prod_q;
	logic [READ_W-1:0]   rem_q;
	logic [DIST_W-1:0]   num_lo_q;
	logic [DIST_W-1:0]   quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIST_W-1:0]   dist_q;
	clamp_t              clamp_q;
	logic                m_valid_q;
	logic [DIST_W-1:0]   m_dist_q;
	clamp_t              m_clamp_q;

	// Shared subtractor operands
	logic [SUB_W-1:0]    sub_a;
	logic [SUB_W-1:0]    sub_b;
	logic [SUB_W-1:0]    sub_res;
	logic                sub_neg;
	logic                sub_zero;
	logic [READ_W:0]     trial;

	// Segment values for the multiply cycles
	logic [IDX_W-1:0]    seg_nx;
	logic [READ_W-1:0]   seg_step;
	logic [DIST_W-1:0]   y0;
	logic [DIST_W-1:0]   y1;
	logic signed [DIST_W:0]  dy;
	logic signed [NUM_W+1:0] num_s;
	logic [NUM_W-1:0]    num;

	assign seg_nx   = seg_q + IDX_W'(1);
	assign y0       = dist_at(seg_q);
	assign y1       = dist_at(seg_nx);
	assign seg_step = bp_at(front_q, seg_nx) - bp_at(front_q, seg_q);
	assign dy       = $signed({1'b0, y1}) - $signed({1'b0, y0});

	// Numerator y0*step + (y1-y0)*diff, never negative for an enclosing segment
	assign num_s = $signed({2'b00, prod_q}) + (dy * $signed({1'b0, diff_q}));
	assign num   = num_s[NUM_W-1:0];

	// Divider trial: partial remainder shifted with the next numerator bit
	assign trial = {rem_q, num_lo_q[DIST_W-1]};

	// Shared subtractor input select
	always_comb begin
		sub_a = {2'b00, read_q};
		sub_b = '0;
		unique case (state_q)
			ST_LO:     sub_b = {2'b00, bp_at(front_q, '0)};
			ST_HI:     sub_b = {2'b00, bp_at(front_q, IDX_W'(TABLE_ENTRIES - 1))};
			ST_SEARCH: sub_b = {2'b00, bp_at(front_q, seg_nx)};
			ST_MUL1:   sub_b = {2'b00, bp_at(front_q, seg_q)};
			ST_DIV: begin
				sub_a = {1'b0, trial};
				sub_b = {2'b00, step_q};
			end
			default: begin
				sub_a = {2'b00, read_q};
				sub_b = '0;
			end
		endcase
	end

	assign sub_res  = sub_a - sub_b;
	assign sub_neg  = sub_res[SUB_W-1];
	assign sub_zero = (sub_res == '0);

	// Sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			// Output taken; a finishing item refills it in ST_DONE instead
			if (m_valid_q && m_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						front_q <= (s_tuser == '0);
						read_q  <= s_tdata[READ_W-1:0];
						state_q <= ST_LO;
					end
				end
				// At or below the first breakpoint
				ST_LO: begin
					if (sub_neg || sub_zero) begin
						dist_q  <= DIST_Q4[0];
						clamp_q <= CLAMP_FIRST;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_HI;
					end
				end
				// At or above the last breakpoint
				ST_HI: begin
					if (!sub_neg) begin
						dist_q  <= DIST_Q4[TABLE_ENTRIES - 1];
						clamp_q <= CLAMP_LAST;
						state_q <= ST_DONE;
					end else begin
						seg_q   <= '0;
						state_q <= ST_SEARCH;
					end
				end
				// First segment whose upper end is at or above the reading
				ST_SEARCH: begin
					if (sub_neg || sub_zero) begin
						state_q <= ST_MUL1;
					end else begin
						seg_q <= seg_nx;
					end
				end
				ST_MUL1: begin
					diff_q  <= sub_res[READ_W-1:0];
					step_q  <= seg_step;
					prod_q  <= NUM_W'(y0) * NUM_W'(seg_step);
					state_q <= ST_MUL2;
				end
				// Quotient fits in DIST_W bits, so the high part is below step
				ST_MUL2: begin
					rem_q    <= num[NUM_W-1:DIST_W];
					num_lo_q <= num[DIST_W-1:0];
					quo_q    <= '0;
					cnt_q    <= '0;
					clamp_q  <= CLAMP_NONE;
					state_q  <= ST_DIV;
				end
				// Restoring divide, one quotient bit a cycle
				ST_DIV: begin
					num_lo_q <= {num_lo_q[DIST_W-2:0], 1'b0};
					if (!sub_neg) begin
						rem_q <= sub_res[READ_W-1:0];
						quo_q <= {quo_q[DIST_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[READ_W-1:0];
						quo_q <= {quo_q[DIST_W-2:0], 1'b0};
					end
					if (cnt_q == CNT_W'(DIST_W - 1)) begin
						dist_q  <= sub_neg ? {quo_q[DIST_W-2:0], 1'b0}
						                   : {quo_q[DIST_W-2:0], 1'b1};
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				// Hand the item to the output register once it is free
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_dist_q  <= dist_q;
						m_clamp_q <= clamp_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(16 - DIST_W){1'b0}}, m_dist_q};
	assign m_tuser  = m_clamp_q;

	// Checks
	`IRDTI_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	`IRDTI_ASSERT_SAME(a_first_dist, m_tvalid && (m_tuser == CLAMP_FIRST), m_tdata[DIST_W-1:0] == DIST_Q4[0], "first clamp distance")
	`IRDTI_ASSERT_SAME(a_last_dist, m_tvalid && (m_tuser == CLAMP_LAST), m_tdata[DIST_W-1:0] == DIST_Q4[TABLE_ENTRIES - 1], "last clamp distance")
	`IRDTI_ASSERT_SAME(a_dist_range, m_tvalid, m_tdata[DIST_W-1:0] <= DIST_Q4[0] && m_tdata[DIST_W-1:0] >= DIST_Q4[TABLE_ENTRIES - 1], "distance out of table range")

endmodule

// ===== dv/ir_distance_table_interpolator_tb.sv =====
module ir_distance_table_interpolator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import irdti_pkg::*;

	localparam int ENTRIES     = 14;
	localparam int CYCLE_LIMIT = 1_000_000;
	// Longest accept-to-output time of the block, plus margin
	localparam int SETTLE      = 40;
	localparam int PHASE_ITEMS = 660;

	// Calibration tables, kept independent of the design's own copy
	localparam logic [13:0] FRONT_BP [ENTRIES] = '{
		14'd1904, 14'd1920, 14'd1936, 14'd1952, 14'd1968, 14'd2101, 14'd2320,
		14'd2571, 14'd2880, 14'd3443, 14'd4157, 14'd5210, 14'd6826, 14'd8699
	};
	localparam logic [13:0] SIDE_BP [ENTRIES] = '{
		14'd1311, 14'd1475, 14'd1638, 14'd1802, 14'd1966, 14'd2130, 14'd2294,
		14'd2621, 14'd2949, 14'd3441, 14'd4096, 14'd5079, 14'd6554, 14'd8192
	};
	localparam logic [11:0] RANGE_CM_Q4 [ENTRIES] = '{
		12'd2400, 12'd2240, 12'd2080, 12'd1920, 12'd1760, 12'd1600, 12'd1440,
		12'd1280, 12'd1120, 12'd960,  12'd800,  12'd640,  12'd480,  12'd320
	};

	typedef struct packed {
		logic [2:0]  ch;
		logic [13:0] reading;
		logic        drain;  // hold until all earlier results are out
	} sensor_item_t;

	typedef struct packed {
		logic [11:0] cm_q4;
		clamp_t      kind;
	} distance_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	sensor_item_t pending_readings[$];
	distance_t    expected_distances[$];
	logic         item_taken = 1'b0;
	int           send_idle_pct = 38;
	int           recv_stall_pct = 66;
	int           n_errors = 0;
	int           cycle_count = 0;

	ir_distance_table_interpolator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	function automatic logic [13:0] breakpoint(input logic front, input int idx);
		return front ? FRONT_BP[idx] : SIDE_BP[idx];
	endfunction

	// Table lookup with clamping and truncating linear interpolation
	function automatic distance_t interpolate_distance(input logic [2:0] ch,
		input logic [13:0] r);
		distance_t res;
		logic      front;
		logic      found;
		longint    x0, x1, y0, y1, num;
		front     = (ch == 3'd0);
		found     = 1'b0;
		res.cm_q4 = RANGE_CM_Q4[0];
		res.kind  = CLAMP_NONE;
		if (r <= breakpoint(front, 0)) begin
			res.kind = CLAMP_FIRST;
		end else if (r >= breakpoint(front, ENTRIES - 1)) begin
			res.cm_q4 = RANGE_CM_Q4[ENTRIES - 1];
			res.kind  = CLAMP_LAST;
		end else begin
			for (int i = 0; i < ENTRIES - 1; i++) begin
				x0 = longint'(breakpoint(front, i));
				x1 = longint'(breakpoint(front, i + 1));
				if (!found && x0 <= longint'(r) && longint'(r) <= x1) begin
					found = 1'b1;
					y0 = longint'(RANGE_CM_Q4[i]);
					y1 = longint'(RANGE_CM_Q4[i + 1]);
					if (x1 <= x0) begin
						res.cm_q4 = 12'(y0);
					end else begin
						num = y0 * (x1 - x0) + (y1 - y0) * (longint'(r) - x0);
						res.cm_q4 = (num < 0) ? 12'd0 : 12'(num / (x1 - x0));
					end
				end
			end
		end
		return res;
	endfunction

	// Mostly readings inside the table span, some near breakpoints, some anywhere
	function automatic sensor_item_t random_reading();
		sensor_item_t it;
		int           pick;
		int           k;
		logic         front;
		it.ch = 3'($urandom_range(7));
		front = (it.ch == 3'd0);
		pick  = $urandom_range(99);
		if (pick < 65) begin
			it.reading = 14'($urandom_range(breakpoint(front, ENTRIES - 1),
				breakpoint(front, 0)));
		end else if (pick < 80) begin
			k = $urandom_range(ENTRIES - 1);
			it.reading = 14'(int'(breakpoint(front, k)) + $urandom_range(2) - 1);
		end else begin
			it.reading = 14'($urandom_range(16383));
		end
		it.drain = ($urandom_range(249) == 0);
		return it;
	endfunction

	task automatic queue_reading(input logic [2:0] ch, input logic [13:0] r,
		input logic drain);
		sensor_item_t it;
		it.ch      = ch;
		it.reading = r;
		it.drain   = drain;
		pending_readings.push_back(it);
	endtask

	// Driver: inputs change on the falling edge
	always @(negedge clk) begin
		sensor_item_t nxt;
		if (arst_n) begin
			if (!s_tvalid || item_taken) begin
				if (pending_readings.size() > 0
					&& $urandom_range(99) >= send_idle_pct
					&& (!pending_readings[0].drain || expected_distances.size() == 0)) begin
					nxt = pending_readings.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {2'b00, nxt.reading};
					s_tuser  <= nxt.ch;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: check results first, then record newly accepted items
	always @(posedge clk) begin
		distance_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_distances.size() == 0) begin
					$display("%0t: unexpected item tdata=%0d tuser=%0d", $time, m_tdata,
						m_tuser);
					n_errors++;
				end else begin
					want = expected_distances.pop_front();
					if (m_tdata !== {4'b0000, want.cm_q4}) begin
						$display("%0t: distance mismatch expected %0d actual %0d", $time,
							want.cm_q4, m_tdata);
						n_errors++;
					end
					if (m_tuser !== want.kind) begin
						$display("%0t: clamp mismatch expected %0d actual %0d", $time,
							want.kind, m_tuser);
						n_errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_distances.push_back(interpolate_distance(s_tuser, s_tdata[13:0]));
			end
		end
		item_taken <= arst_n && s_tvalid && s_tready;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL ir_distance_table_interpolator");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: clamps at both ends, exact breakpoints, channel 7
		queue_reading(3'd0, 14'd0, 1'b0);
		queue_reading(3'd1, 14'd0, 1'b0);
		queue_reading(3'd0, 14'd16383, 1'b0);
		queue_reading(3'd7, 14'd16383, 1'b0);
		queue_reading(3'd0, 14'd1904, 1'b0);
		queue_reading(3'd0, 14'd1905, 1'b0);
		queue_reading(3'd0, 14'd8699, 1'b0);
		queue_reading(3'd0, 14'd8698, 1'b0);
		queue_reading(3'd2, 14'd1311, 1'b0);
		queue_reading(3'd3, 14'd1312, 1'b0);
		queue_reading(3'd4, 14'd8192, 1'b0);
		queue_reading(3'd5, 14'd8191, 1'b0);
		queue_reading(3'd6, 14'd2621, 1'b0);
		queue_reading(3'd0, 14'd2880, 1'b0);
		queue_reading(3'd0, 14'd1920, 1'b0);
		queue_reading(3'd7, 14'd5000, 1'b0);
		queue_reading(3'd1, 14'd1903, 1'b0);
		queue_reading(3'd0, 14'd1310, 1'b0);
		queue_reading(3'd6, 14'd8200, 1'b0);
		queue_reading(3'd0, 14'd8200, 1'b0);
		queue_reading(3'd3, 14'd9999, 1'b1);
		queue_reading(3'd0, 14'd8191, 1'b0);

		// Random: sender idles less than receiver
		repeat (PHASE_ITEMS) pending_readings.push_back(random_reading());
		wait (pending_readings.size() == 0);

		// Random: receiver idles less than sender
		send_idle_pct  = 66;
		recv_stall_pct = 38;
		repeat (PHASE_ITEMS) pending_readings.push_back(random_reading());
		wait (pending_readings.size() == 0);

		// Random: full throughput
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (PHASE_ITEMS) pending_readings.push_back(random_reading());

		while (pending_readings.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_distances.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (n_errors == 0 && expected_distances.size() == 0) begin
			$display("PASS ir_distance_table_interpolator");
		end else begin
			$display("FAIL ir_distance_table_interpolator");
		end
		$finish;
	end

endmodule
